// ===== rtl/tmms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmms_pkg
// Types, codes and reset values shared by the track marker mode sequencer.
// ----------------------------------------------------------------------------
package tmms_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_SPEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOK_DIST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WALK_DIST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TIME    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS     = 3'd5;

    // Configuration reset values.
    localparam logic [6:0]  RST_NORMAL_SPEED = 7'd50;
    localparam logic [6:0]  RST_MAX_SPEED    = 7'd90;
    localparam logic [15:0] RST_LOOK_DIST    = 16'd60;
    localparam logic [15:0] RST_WALK_DIST    = 16'd80;
    localparam logic [23:0] RST_STOP_TIME    = 24'(5000 * 1000);
    localparam logic [7:0]  RST_MIN_HITS     = 8'd2;

    // Modes.
    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_LOOKING  = 2'd1;
    localparam logic [1:0] MODE_WALKSTOP = 2'd2;
    localparam logic [1:0] MODE_MAXSPEED = 2'd3;

    // Drive commands.
    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_FOLLOW = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;

    // Request kinds.
    localparam logic FUNC_MARKER = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    localparam logic [7:0] LED_FULL  = 8'hFF;
    localparam logic [6:0] SPEED_CAP = 7'd100;

    typedef struct packed {
        logic               func;
        logic               marker_seen;
        logic signed [15:0] distance_mm;
        logic        [19:0] elapsed_us;
    } t_in;

    typedef struct packed {
        logic [1:0] drive_cmd;
        logic [6:0] drive_speed;
        logic       led_write;
        logic [7:0] led_red;
        logic [7:0] led_green;
        logic [7:0] led_blue;
        logic [1:0] mode;
    } t_out;

    typedef struct packed {
        logic [6:0]  normal_speed;
        logic [6:0]  max_speed;
        logic [15:0] look_distance_mm;
        logic [15:0] walk_distance_mm;
        logic [23:0] stop_time_us;
        logic [7:0]  marker_min_hits;
    } t_cfg;

endpackage

// ===== rtl/track_marker_mode_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_marker_mode_sequencer_unit
// Mode sequencer for a line-following vehicle: marker samples and control
// ticks in, one drive/LED result per request out.
// ----------------------------------------------------------------------------
// A request is held in the input register, its result in the result
// register. Throughput: one request per cycle unless the output stalls;
// the state update between the two registers is the single loop for this.
// Reset (synchronous, active low) sets normal mode, clears the counters and
// loads the default register values; no clearing pass is needed.
module track_marker_mode_sequencer_unit
    import tmms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data
);

    t_cfg r_cfg;
    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;
    t_out w_res;
    logic w_load;
    logic w_adv;
    logic w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_speed     <= RST_NORMAL_SPEED;
            r_cfg.max_speed        <= RST_MAX_SPEED;
            r_cfg.look_distance_mm <= RST_LOOK_DIST;
            r_cfg.walk_distance_mm <= RST_WALK_DIST;
            r_cfg.stop_time_us     <= RST_STOP_TIME;
            r_cfg.marker_min_hits  <= RST_MIN_HITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NORMAL_SPEED: r_cfg.normal_speed     <= i_cfg_wdata[6:0];
                CFG_MAX_SPEED:    r_cfg.max_speed        <= i_cfg_wdata[6:0];
                CFG_LOOK_DIST:    r_cfg.look_distance_mm <= i_cfg_wdata[15:0];
                CFG_WALK_DIST:    r_cfg.walk_distance_mm <= i_cfg_wdata[15:0];
                CFG_STOP_TIME:    r_cfg.stop_time_us     <= i_cfg_wdata[23:0];
                CFG_MIN_HITS:     r_cfg.marker_min_hits  <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // The result register loads whenever it is empty or being drained.
    assign w_load     = !r_out_valid || !i_out_stall;
    assign w_adv      = r_in_valid && w_load;
    assign o_in_stall = r_in_valid && !w_load;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    tmms_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_out_valid)
        else $error("request left the input stage but no result appeared");

    a_led_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.led_write) |->
        (o_out_data.led_red == 8'd0 && o_out_data.led_green == 8'd0 &&
         o_out_data.led_blue == 8'd0))
        else $error("LED colour set without an LED write");

    a_speed_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.drive_cmd != CMD_FOLLOW) |->
        o_out_data.drive_speed == 7'd0)
        else $error("speed given without a follow command");

    a_speed_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.drive_speed <= SPEED_CAP)
        else $error("speed above the cap");

endmodule

// ===== rtl/tmms_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmms_step
// Sequencer state and the single-pass update for one request.
// ----------------------------------------------------------------------------
module tmms_step
    import tmms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_in  i_item,
    input  t_cfg i_cfg,
    output t_out o_res
);

    logic [1:0]         r_mode, n_mode;
    logic [15:0]        r_hits, n_hits;
    logic signed [31:0] r_dist, n_dist;
    logic [31:0]        r_stop, n_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_hits <= '0;
            r_dist <= '0;
            r_stop <= '0;
        end else if (i_en) begin
            r_mode <= n_mode;
            r_hits <= n_hits;
            r_dist <= n_dist;
            r_stop <= n_stop;
        end
    end

    function automatic logic [6:0] clamp_speed(input logic [6:0] s);
        return (s > SPEED_CAP) ? SPEED_CAP : s;
    endfunction

    always_comb begin
        logic signed [32:0] dsum;
        logic signed [31:0] dsat;
        logic        [32:0] tsum;
        logic        [31:0] tsat;

        n_mode = r_mode;
        n_hits = r_hits;
        n_dist = r_dist;
        n_stop = r_stop;
        o_res  = '0;

        dsum = {r_dist[31], r_dist} + 33'(i_item.distance_mm);
        if (dsum[32] != dsum[31]) begin
            dsat = dsum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            dsat = dsum[31:0];
        end
        tsum = {1'b0, r_stop} + {13'd0, i_item.elapsed_us};
        tsat = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];

        if (i_item.func == FUNC_MARKER) begin
            if (i_item.marker_seen) begin
                if (r_hits != 16'hFFFF) begin
                    n_hits = r_hits + 16'd1;
                end
            end else begin
                n_hits = '0;
                if (r_hits > {8'd0, i_cfg.marker_min_hits}) begin
                    n_dist = '0;
                    o_res.led_write = 1'b1;
                    unique case (r_mode)
                        MODE_NORMAL:   n_mode = MODE_LOOKING;
                        MODE_LOOKING: begin
                            n_mode = MODE_WALKSTOP;
                            o_res.led_red  = LED_FULL;
                            o_res.led_blue = LED_FULL;
                        end
                        MODE_WALKSTOP: begin
                            n_mode = MODE_MAXSPEED;
                            o_res.led_green = LED_FULL;
                            o_res.led_blue  = LED_FULL;
                        end
                        default:       n_mode = MODE_NORMAL;
                    endcase
                end
            end
        end else begin
            n_dist = dsat;
            unique case (r_mode)
                MODE_NORMAL: begin
                    o_res.drive_cmd   = CMD_FOLLOW;
                    o_res.drive_speed = clamp_speed(i_cfg.normal_speed);
                end
                MODE_LOOKING: begin
                    o_res.drive_cmd   = CMD_FOLLOW;
                    o_res.drive_speed = clamp_speed(i_cfg.normal_speed);
                    if (dsat > $signed({16'd0, i_cfg.look_distance_mm})) begin
                        n_mode = MODE_MAXSPEED;
                        n_dist = '0;
                        o_res.led_write = 1'b1;
                        o_res.led_green = LED_FULL;
                        o_res.led_blue  = LED_FULL;
                    end
                end
                MODE_MAXSPEED: begin
                    o_res.drive_cmd   = CMD_FOLLOW;
                    o_res.drive_speed = clamp_speed(i_cfg.max_speed);
                    o_res.led_write   = 1'b1;
                    o_res.led_green   = LED_FULL;
                    o_res.led_blue    = LED_FULL;
                end
                default: begin
                    if (dsat >= $signed({16'd0, i_cfg.walk_distance_mm})) begin
                        if (tsat >= {8'd0, i_cfg.stop_time_us}) begin
                            // The stop ends in this tick: report the return to normal.
                            n_mode = MODE_NORMAL;
                            n_stop = '0;
                            n_dist = '0;
                            o_res.led_write   = 1'b1;
                            o_res.drive_cmd   = CMD_FOLLOW;
                            o_res.drive_speed = clamp_speed(i_cfg.normal_speed);
                        end else begin
                            n_stop = tsat;
                            o_res.led_write = 1'b1;
                            o_res.led_red   = LED_FULL;
                            o_res.led_blue  = LED_FULL;
                            o_res.drive_cmd = CMD_STOP;
                        end
                    end else begin
                        o_res.led_write   = 1'b1;
                        o_res.led_red     = LED_FULL;
                        o_res.led_blue    = LED_FULL;
                        o_res.drive_cmd   = CMD_FOLLOW;
                        o_res.drive_speed = clamp_speed(i_cfg.normal_speed);
                    end
                end
            endcase
        end
        o_res.mode = n_mode;
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the track marker mode sequencer. A driver feeds
// marker samples and control ticks from a request queue while both sides
// idle and stall at random. A predictor that keeps its own mode, hit count,
// distance and stopped-time state computes each expected drive/LED result.
// A monitor compares every result, field by field, against the oldest
// prediction. The run covers directed mode walks, several register settings
// including the extremes, long runs of full-scale ticks in walk-and-stop and
// a long hit run.
// ----------------------------------------------------------------------------
module testbench;
    import tmms_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int STALL_LIMIT = 1000;
    localparam int LONG_RUN    = 60;

    localparam logic [CFG_IDX_W-1:0] CFG_PAST_LAST = 3'd6;

    localparam longint ACC_MAX  = 64'sh7FFF_FFFF;
    localparam longint ACC_MIN  = -64'sh8000_0000;
    localparam longint TIME_MAX = 64'sh0_FFFF_FFFF;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid  = 1'b0;
    t_in                   i_in_data   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out                  o_out_data;

    // Predictor state and its copy of the registers.
    t_cfg        cfg_now;
    logic [1:0]  mode_now;
    logic [15:0] hit_count;
    int          dist_acc;
    logic [31:0] stop_time_acc;

    t_in  pending_requests [$];
    t_out awaited_results [$];

    bit req_taken = 1'b0;
    bit drive_on  = 1'b0;
    int idle_pct  = 9;
    int stall_pct = 9;

    int requests_queued = 0;
    int requests_seen   = 0;
    int results_checked = 0;
    int failures        = 0;
    int phase_count     = 0;
    int idle_cycles     = 0;
    int results_per_mode [4] = '{0, 0, 0, 0};

    always #HALF_PERIOD i_clk = ~i_clk;

    track_marker_mode_sequencer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    function automatic t_out with_led(input t_out r, input logic [7:0] red,
                                      input logic [7:0] green, input logic [7:0] blue);
        r.led_write = 1'b1;
        r.led_red   = red;
        r.led_green = green;
        r.led_blue  = blue;
        return r;
    endfunction

    function automatic t_out follow_at(input t_out r, input logic [6:0] spd);
        r.drive_cmd   = CMD_FOLLOW;
        r.drive_speed = (spd > SPEED_CAP) ? SPEED_CAP : spd;
        return r;
    endfunction

    function automatic t_out next_drive_result(input t_in req);
        t_out   res;
        longint sum;
        longint stopped;
        res = '0;
        if (req.func == FUNC_MARKER) begin
            if (req.marker_seen) begin
                if (hit_count != 16'hFFFF) hit_count = hit_count + 16'd1;
            end else begin
                if (hit_count > {8'd0, cfg_now.marker_min_hits}) begin
                    case (mode_now)
                        MODE_NORMAL: begin
                            mode_now = MODE_LOOKING;
                            res = with_led(res, 8'd0, 8'd0, 8'd0);
                        end
                        MODE_LOOKING: begin
                            mode_now = MODE_WALKSTOP;
                            res = with_led(res, LED_FULL, 8'd0, LED_FULL);
                        end
                        MODE_WALKSTOP: begin
                            mode_now = MODE_MAXSPEED;
                            res = with_led(res, 8'd0, LED_FULL, LED_FULL);
                        end
                        default: begin
                            mode_now = MODE_NORMAL;
                            res = with_led(res, 8'd0, 8'd0, 8'd0);
                        end
                    endcase
                    dist_acc = 0;
                end
                hit_count = '0;
            end
        end else begin
            sum = longint'(dist_acc) + longint'($signed(req.distance_mm));
            if (sum > ACC_MAX) sum = ACC_MAX;
            if (sum < ACC_MIN) sum = ACC_MIN;
            dist_acc = int'(sum);
            case (mode_now)
                MODE_NORMAL: begin
                    res = follow_at(res, cfg_now.normal_speed);
                end
                MODE_LOOKING: begin
                    res = follow_at(res, cfg_now.normal_speed);
                    if (longint'(dist_acc) > longint'(cfg_now.look_distance_mm)) begin
                        mode_now = MODE_MAXSPEED;
                        dist_acc = 0;
                        res = with_led(res, 8'd0, LED_FULL, LED_FULL);
                    end
                end
                MODE_MAXSPEED: begin
                    res = follow_at(res, cfg_now.max_speed);
                    res = with_led(res, 8'd0, LED_FULL, LED_FULL);
                end
                default: begin
                    res = with_led(res, LED_FULL, 8'd0, LED_FULL);
                    if (longint'(dist_acc) >= longint'(cfg_now.walk_distance_mm)) begin
                        stopped = longint'(stop_time_acc) + longint'(req.elapsed_us);
                        if (stopped > TIME_MAX) stopped = TIME_MAX;
                        stop_time_acc = stopped[31:0];
                        res.drive_cmd   = CMD_STOP;
                        res.drive_speed = '0;
                        // A stop that runs out on this tick reports the return to normal.
                        if (stop_time_acc >= {8'd0, cfg_now.stop_time_us}) begin
                            mode_now      = MODE_NORMAL;
                            stop_time_acc = '0;
                            dist_acc      = 0;
                            res = with_led(res, 8'd0, 8'd0, 8'd0);
                            res = follow_at(res, cfg_now.normal_speed);
                        end
                    end else begin
                        res = follow_at(res, cfg_now.normal_speed);
                    end
                end
            endcase
        end
        res.mode = mode_now;
        return res;
    endfunction

    function automatic string show_result(input t_out r);
        return $sformatf("cmd %0d speed %0d led %0d rgb %0d/%0d/%0d mode %0d",
                         r.drive_cmd, r.drive_speed, r.led_write,
                         r.led_red, r.led_green, r.led_blue, r.mode);
    endfunction

    function automatic void queue_request(input t_in req);
        pending_requests.push_back(req);
        requests_queued++;
    endfunction

    // Fields that the request kind does not use are always randomized.
    function automatic void push_marker(input logic seen);
        t_in req;
        req.func        = FUNC_MARKER;
        req.marker_seen = seen;
        req.distance_mm = 16'($urandom);
        req.elapsed_us  = 20'($urandom);
        queue_request(req);
    endfunction

    function automatic void push_tick(input logic signed [15:0] step_mm, input logic [19:0] us);
        t_in req;
        req.func        = FUNC_TICK;
        req.marker_seen = 1'($urandom);
        req.distance_mm = step_mm;
        req.elapsed_us  = us;
        queue_request(req);
    endfunction

    // Mostly well-formed marker runs and tick bursts, with some raw noise.
    function automatic void queue_random_traffic(input int budget);
        int start;
        int pick;
        int n;
        int rsel;
        logic signed [15:0] step_mm;
        logic [19:0] us;
        logic [63:0] rnd;
        logic [$bits(t_in)-1:0] raw;
        start = requests_queued;
        while (requests_queued - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                rnd = {$urandom(), $urandom()};
                raw = rnd[$bits(t_in)-1:0];
                queue_request(raw);
            end else if (pick < 50) begin
                if ($urandom_range(99) < 60)
                    n = int'(cfg_now.marker_min_hits) + $urandom_range(1, 3);
                else
                    n = $urandom_range(0, int'(cfg_now.marker_min_hits) + 3);
                repeat (n) push_marker(1'b1);
                if ($urandom_range(9) != 0) push_marker(1'b0);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    rsel = $urandom_range(99);
                    if (rsel < 40)      step_mm = 16'($urandom_range(150));
                    else if (rsel < 65) step_mm = 16'($urandom_range(32767));
                    else if (rsel < 85) step_mm = 16'(-int'($urandom_range(150)));
                    else                step_mm = 16'($urandom);
                    us = ($urandom_range(99) < 60) ? 20'($urandom) : 20'($urandom_range(1000));
                    push_tick(step_mm, us);
                end
            end
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            CFG_NORMAL_SPEED: cfg_now.normal_speed     = value[6:0];
            CFG_MAX_SPEED:    cfg_now.max_speed        = value[6:0];
            CFG_LOOK_DIST:    cfg_now.look_distance_mm = value[15:0];
            CFG_WALK_DIST:    cfg_now.walk_distance_mm = value[15:0];
            CFG_STOP_TIME:    cfg_now.stop_time_us     = value[23:0];
            CFG_MIN_HITS:     cfg_now.marker_min_hits  = value[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Upper bits beyond each register's width carry junk that must be dropped.
    task automatic configure(input int ns, input int ms, input int look, input int walk,
                             input int stop, input int hits);
        write_reg(CFG_PAST_LAST + 3'($urandom_range(1)), 24'($urandom));
        write_reg(CFG_NORMAL_SPEED, {17'($urandom), 7'(ns)});
        write_reg(CFG_MAX_SPEED, {17'($urandom), 7'(ms)});
        write_reg(CFG_LOOK_DIST, {8'($urandom), 16'(look)});
        write_reg(CFG_WALK_DIST, {8'($urandom), 16'(walk)});
        write_reg(CFG_STOP_TIME, 24'(stop));
        write_reg(CFG_MIN_HITS, {16'($urandom), 8'(hits)});
        phase_count++;
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_requests.size() != 0 || i_in_valid ||
                   awaited_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Driver and output stall.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
        if (!i_in_valid || req_taken) begin
            if (drive_on && pending_requests.size() != 0 &&
                    $urandom_range(99) >= idle_pct) begin
                i_in_data  <= pending_requests.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Prediction on each accepted request, checking on each accepted result.
    always @(posedge i_clk) begin : monitor
        t_out wanted;
        bit   progress;
        progress  = 1'b0;
        req_taken = i_in_valid && !o_in_stall;
        if (req_taken) begin
            awaited_results.push_back(next_drive_result(i_in_data));
            requests_seen++;
            progress = 1'b1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            progress = 1'b1;
            if (awaited_results.size() == 0) begin
                if (failures < 10)
                    $display("%0t: result with nothing expected: %s",
                             $time, show_result(o_out_data));
                failures++;
            end else begin
                wanted = awaited_results.pop_front();
                results_checked++;
                results_per_mode[wanted.mode]++;
                if (o_out_data.drive_cmd !== wanted.drive_cmd ||
                        o_out_data.drive_speed !== wanted.drive_speed ||
                        o_out_data.led_write !== wanted.led_write ||
                        o_out_data.led_red !== wanted.led_red ||
                        o_out_data.led_green !== wanted.led_green ||
                        o_out_data.led_blue !== wanted.led_blue ||
                        o_out_data.mode !== wanted.mode) begin
                    if (failures < 10)
                        $display("%0t: mismatch, expected %s, got %s", $time,
                                 show_result(wanted), show_result(o_out_data));
                    failures++;
                end
            end
        end
        idle_cycles = progress ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        int steps;
        cfg_now = '{normal_speed: RST_NORMAL_SPEED, max_speed: RST_MAX_SPEED,
                    look_distance_mm: RST_LOOK_DIST, walk_distance_mm: RST_WALK_DIST,
                    stop_time_us: RST_STOP_TIME, marker_min_hits: RST_MIN_HITS};
        mode_now      = MODE_NORMAL;
        hit_count     = '0;
        dist_acc      = 0;
        stop_time_acc = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        drive_on = 1'b1;

        // Reset settings: ticks in normal mode, a run too short to advance and one
        // that does, the look threshold at and just past equality, a max-speed tick.
        push_tick(16'sd0, 20'd0);
        push_tick(-16'sd32768, 20'hFFFFF);
        push_marker(1'b0);
        repeat (2) push_marker(1'b1);
        push_marker(1'b0);
        repeat (3) push_marker(1'b1);
        push_marker(1'b0);
        push_tick(16'sd60, 20'd0);
        push_tick(16'sd1, 20'd20);
        push_tick(16'sd32767, 20'hFFFFF);
        wait_idle();

        // Single-hit advances around to walk-and-stop, then a stop that runs
        // out on the fifth tick and reports the return to normal.
        write_reg(CFG_MIN_HITS, 24'd0);
        repeat (3) begin
            push_marker(1'b1);
            push_marker(1'b0);
        end
        push_tick(16'sd79, 20'd5);
        push_tick(16'sd1, 20'hFFFFF);
        repeat (4) push_tick(16'sd0, 20'hFFFFF);
        wait_idle();

        configure(127, 101, 0, 0, 0, 0);
        queue_random_traffic(150);
        wait_idle();

        configure(100, 0, 65535, 65535, 16777215, 255);
        queue_random_traffic(100);
        wait_idle();

        idle_pct  = 0;
        stall_pct = 0;
        configure($urandom_range(127), $urandom_range(127), $urandom_range(2000),
                  $urandom_range(2000), $urandom_range(3000000), $urandom_range(6));
        queue_random_traffic(150);
        wait_idle();
        idle_pct  = 9;
        stall_pct = 9;

        configure(0, 100, 1, 1, 1, 1);
        queue_random_traffic(150);
        wait_idle();

        repeat (2) begin
            configure($urandom_range(127), $urandom_range(127), $urandom_range(2000),
                      $urandom_range(2000), $urandom_range(3000000), $urandom_range(6));
            queue_random_traffic(150);
            wait_idle();
        end

        // Full-scale ticks in walk-and-stop, first backward and then forward,
        // so the accumulated distance swings far to both sides.
        configure(60, 95, 65535, 100, 16777215, 0);
        steps = (int'(MODE_WALKSTOP) - int'(mode_now) + 4) % 4;
        repeat (steps) begin
            push_marker(1'b1);
            push_marker(1'b0);
        end
        repeat (LONG_RUN) push_tick(-16'sd32768, 20'd0);
        repeat (4) begin
            push_marker(1'b1);
            push_marker(1'b0);
        end
        repeat (LONG_RUN) push_tick(16'sd32767, 20'd0);
        wait_idle();

        // A long hit run past a high threshold advances the mode.
        write_reg(CFG_MIN_HITS, 24'd50);
        repeat (LONG_RUN) push_marker(1'b1);
        push_marker(1'b0);
        wait_idle();

        failures += awaited_results.size();
        $display("testbench: %0d requests and %0d results checked over %0d register settings",
                 requests_seen, results_checked, phase_count);
        $display("testbench: results by mode normal %0d, looking %0d, walk-stop %0d, max %0d",
                 results_per_mode[0], results_per_mode[1], results_per_mode[2],
                 results_per_mode[3]);
        if (failures == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tmms_pkg.sv
rtl/tmms_step.sv
rtl/track_marker_mode_sequencer_unit.sv
verif/testbench.sv
